@@ rtl/core/civil_date_to_day_serial_defines.svh @@
// ----------------------------------------------------------------------------
// civil_date_to_day_serial_defines
// Assertion macros for the date-serial RTL.
// ----------------------------------------------------------------------------
`ifndef CIVIL_DATE_TO_DAY_SERIAL_DEFINES_SVH
`define CIVIL_DATE_TO_DAY_SERIAL_DEFINES_SVH

// check a property on every clock edge outside reset
`define CDDS_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// check that a condition implies a consequence in the same cycle
`define CDDS_ASSERT_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/cdds_pkg.sv @@
// ----------------------------------------------------------------------------
// cdds_pkg
// Types, constants and tables for the civil date to day serial converter.
// ----------------------------------------------------------------------------
package cdds_pkg;

   typedef struct packed {
      logic signed [15:0] year_in;
      logic signed [15:0] month_in;
      logic signed [15:0] day_in;
   } req_type;

   typedef struct packed {
      logic signed [22:0] serial;
      logic [1:0]         status;
   } rsp_type;

   typedef struct packed {
      logic               bad_year;
      logic [17:0]        total;
      logic signed [15:0] day;
   } work_type;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_BAD_YEAR = 2'd1;
   localparam logic [1:0] STATUS_BAD_DATE = 2'd2;

   localparam logic signed [15:0] YEAR_MAX        = 16'sd9999;
   localparam logic [13:0]        YEAR_LAST_SHORT = 14'd1899;
   localparam logic [13:0]        YEAR_BASE       = 14'd1900;
   localparam logic [13:0]        YEAR_SHIFT      = 14'd4000;

   localparam logic [16:0] RECIP_3  = 17'd43691;
   localparam logic [12:0] RECIP_25 = 13'd5243;

   localparam logic signed [23:0] DAY_OFFSET = 24'sd2154872;
   localparam logic signed [23:0] DAY_LO     = -24'sd182621;
   localparam logic signed [23:0] DAY_HI     = 24'sd2958463;
   localparam logic signed [23:0] LEAP_LAST  = 24'sd58;

   function automatic logic [8:0] doy_of(input logic [3:0] mp);
      logic [8:0] d;
      unique case (mp)
         4'd0:    d = 9'd0;
         4'd1:    d = 9'd31;
         4'd2:    d = 9'd61;
         4'd3:    d = 9'd92;
         4'd4:    d = 9'd122;
         4'd5:    d = 9'd153;
         4'd6:    d = 9'd184;
         4'd7:    d = 9'd214;
         4'd8:    d = 9'd245;
         4'd9:    d = 9'd275;
         4'd10:   d = 9'd306;
         4'd11:   d = 9'd337;
         default: d = 9'd0;
      endcase
      return d;
   endfunction

endpackage

@@ rtl/core/cdds_front.sv @@
// ----------------------------------------------------------------------------
// cdds_front
// Accept requests, flag bad years and fold year and month into a month count.
// ----------------------------------------------------------------------------
module cdds_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  cdds_pkg::req_type req_payload,
   output logic              work_valid,
   input  logic              work_stall,
   output cdds_pkg::work_type work_data
);

   logic               valid_ff;
   cdds_pkg::work_type data_ff;
   cdds_pkg::work_type data_in;
   logic [13:0]        yr;
   logic [13:0]        ya;
   logic [13:0]        ys;
   logic [17:0]        ys12;
   logic signed [18:0] tot;

   always_comb begin
      yr   = req_payload.year_in[13:0];
      ya   = (yr <= cdds_pkg::YEAR_LAST_SHORT) ? yr + cdds_pkg::YEAR_BASE : yr;
      ys   = ya + cdds_pkg::YEAR_SHIFT;
      ys12 = 18'({ys, 3'b000}) + 18'({ys, 2'b00});
      tot  = $signed({1'b0, ys12}) + 19'(req_payload.month_in) - 19'sd1;
      data_in.bad_year = (req_payload.year_in < 16'sd0) ||
                         (req_payload.year_in > cdds_pkg::YEAR_MAX);
      data_in.total    = tot[17:0];
      data_in.day      = req_payload.day_in;
   end

   assign req_stall  = valid_ff && work_stall;
   assign work_valid = valid_ff;
   assign work_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!req_stall) begin
         valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

@@ rtl/core/cdds_queue.sv @@
// ----------------------------------------------------------------------------
// cdds_queue
// Two-entry queue between the front and the back of the converter.
// ----------------------------------------------------------------------------
module cdds_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_stall,
   input  cdds_pkg::work_type in_data,
   output logic               out_valid,
   input  logic               out_stall,
   output cdds_pkg::work_type out_data
);

   cdds_pkg::work_type mem_ff [2];
   logic               wr_ptr_ff;
   logic               rd_ptr_ff;
   logic [1:0]         count_ff;
   logic [1:0]         count_in;
   logic               push;
   logic               pop;

   assign in_stall  = (count_ff == 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = mem_ff[rd_ptr_ff];
   assign push      = in_valid && !in_stall;
   assign pop       = out_valid && !out_stall;

   always_comb begin
      count_in = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

@@ rtl/core/cdds_back.sv @@
// ----------------------------------------------------------------------------
// cdds_back
// Six-stage pipeline: split the month count, build the day count, range check.
// ----------------------------------------------------------------------------
`include "civil_date_to_day_serial_defines.svh"

module cdds_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               work_valid,
   output logic               work_stall,
   input  cdds_pkg::work_type work_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output cdds_pkg::rsp_type  rsp_payload
);

   logic [6:1] v_ff;
   logic [6:1] v_in;
   logic [6:1] en;

   logic [17:0]        s1_total_ff;
   logic [32:0]        s1_prod_ff;
   logic signed [15:0] s1_day_ff;
   logic               s1_bad_ff;
   logic [32:0]        s1_prod_in;

   logic [14:0]        s2_yy_ff;
   logic signed [23:0] s2_off_ff;
   logic               s2_bad_ff;
   logic [14:0]        s2_yy_in;
   logic signed [23:0] s2_off_in;
   logic [14:0]        ny;
   logic [17:0]        ny12;
   logic [17:0]        diff;
   logic [3:0]         nm0;
   logic [3:0]         mp;
   logic               early;

   logic [22:0]        s3_y365_ff;
   logic [12:0]        s3_y4_ff;
   logic [25:0]        s3_c100_ff;
   logic [23:0]        s3_c400_ff;
   logic signed [23:0] s3_off_ff;
   logic               s3_bad_ff;
   logic [23:0]        s3_y365_in;
   logic [25:0]        s3_c100_in;
   logic [23:0]        s3_c400_in;

   logic [22:0]        s4_acc_ff;
   logic signed [23:0] s4_off_ff;
   logic               s4_bad_ff;
   logic [22:0]        s4_acc_in;

   logic signed [23:0] count_ff;
   logic               s5_bad_ff;
   logic signed [23:0] count_in;

   cdds_pkg::rsp_type  rsp_ff;
   cdds_pkg::rsp_type  rsp_in;
   logic signed [23:0] serial_wide;

   // advance a stage when it is empty or the next one advances
   always_comb begin
      en[6] = !v_ff[6] || !rsp_stall;
      for (int k = 5; k >= 1; k--) begin
         en[k] = !v_ff[k] || en[k + 1];
      end
      v_in[1] = work_valid;
      for (int k = 2; k <= 6; k++) begin
         v_in[k] = v_ff[k - 1];
      end
   end

   assign work_stall  = !en[1];
   assign rsp_valid   = v_ff[6];
   assign rsp_payload = rsp_ff;

   always_comb begin
      s1_prod_in = 33'(work_data.total[17:2]) * 33'(cdds_pkg::RECIP_3);
   end

   always_comb begin
      ny        = s1_prod_ff[31:17];
      ny12      = 18'({ny, 3'b000}) + 18'({ny, 2'b00});
      diff      = s1_total_ff - ny12;
      nm0       = diff[3:0];
      early     = (nm0 < 4'd2);
      s2_yy_in  = early ? ny - 15'd1 : ny;
      mp        = early ? nm0 + 4'd10 : nm0 - 4'd2;
      s2_off_in = 24'(s1_day_ff) + $signed({15'b0, cdds_pkg::doy_of(mp)})
                  - cdds_pkg::DAY_OFFSET;
   end

   always_comb begin
      s3_y365_in = 24'(s2_yy_ff) * 24'd365;
      s3_c100_in = 26'(s2_yy_ff[14:2]) * 26'(cdds_pkg::RECIP_25);
      s3_c400_in = 24'(s2_yy_ff[14:4]) * 24'(cdds_pkg::RECIP_25);
   end

   always_comb begin
      s4_acc_in = s3_y365_ff + 23'(s3_y4_ff) + 23'(s3_c400_ff[23:17])
                  - 23'(s3_c100_ff[25:17]);
   end

   always_comb begin
      count_in = $signed({1'b0, s4_acc_ff}) + s4_off_ff;
   end

   always_comb begin
      serial_wide   = count_ff + ((count_ff > cdds_pkg::LEAP_LAST) ? 24'sd2 : 24'sd1);
      rsp_in.serial = '0;
      priority if (s5_bad_ff) begin
         rsp_in.status = cdds_pkg::STATUS_BAD_YEAR;
      end else if (count_ff < cdds_pkg::DAY_LO || count_ff > cdds_pkg::DAY_HI) begin
         rsp_in.status = cdds_pkg::STATUS_BAD_DATE;
      end else begin
         rsp_in.status = cdds_pkg::STATUS_OK;
         rsp_in.serial = serial_wide[22:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int k = 1; k <= 6; k++) begin
            if (en[k]) begin
               v_ff[k] <= v_in[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         s1_total_ff <= work_data.total;
         s1_prod_ff  <= s1_prod_in;
         s1_day_ff   <= work_data.day;
         s1_bad_ff   <= work_data.bad_year;
      end
      if (en[2]) begin
         s2_yy_ff  <= s2_yy_in;
         s2_off_ff <= s2_off_in;
         s2_bad_ff <= s1_bad_ff;
      end
      if (en[3]) begin
         s3_y365_ff <= s3_y365_in[22:0];
         s3_y4_ff   <= s2_yy_ff[14:2];
         s3_c100_ff <= s3_c100_in;
         s3_c400_ff <= s3_c400_in;
         s3_off_ff  <= s2_off_ff;
         s3_bad_ff  <= s2_bad_ff;
      end
      if (en[4]) begin
         s4_acc_ff <= s4_acc_in;
         s4_off_ff <= s3_off_ff;
         s4_bad_ff <= s3_bad_ff;
      end
      if (en[5]) begin
         count_ff  <= count_in;
         s5_bad_ff <= s4_bad_ff;
      end
      if (en[6]) begin
         rsp_ff <= rsp_in;
      end
   end

   `CDDS_ASSERT(a_stall_hold, v_ff[5] && !en[5] |=> v_ff[5] && $stable(count_ff), "stalled stage lost its count")
   `CDDS_ASSERT_IMPLY(a_no_fake_leap, rsp_valid && rsp_ff.status == cdds_pkg::STATUS_OK, rsp_ff.serial != 23'sd60, "serial of the fictitious leap day produced")
   `CDDS_ASSERT_IMPLY(a_err_zero, rsp_valid && rsp_ff.status != cdds_pkg::STATUS_OK, rsp_ff.serial == 23'sd0, "error response with nonzero serial")
   `CDDS_ASSERT_IMPLY(a_status_code, rsp_valid, rsp_ff.status == cdds_pkg::STATUS_OK || rsp_ff.status == cdds_pkg::STATUS_BAD_YEAR || rsp_ff.status == cdds_pkg::STATUS_BAD_DATE, "undefined status code")

endmodule

@@ rtl/core/civil_date_to_day_serial.sv @@
// ----------------------------------------------------------------------------
// civil_date_to_day_serial
// Year, month and day to spreadsheet day serial, 1900 date system.
// ----------------------------------------------------------------------------
// Takes one request per clock while req_stall is low and returns one response
// per request, in order. A request passes through the front register, the
// two-entry queue and the six-stage back pipeline, whose last stage is the
// response register. A stall on the response side backs up through the back
// pipeline and the queue into req_stall without losing a request. Status 1
// flags a year outside 0..9999, status 2 a date outside 1400-01-01..9999-12-31;
// serial is zero whenever status is nonzero.
// ----------------------------------------------------------------------------
module civil_date_to_day_serial (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  cdds_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output cdds_pkg::rsp_type rsp_payload
);

   logic               f_valid;
   logic               f_stall;
   cdds_pkg::work_type f_data;
   logic               q_valid;
   logic               q_stall;
   cdds_pkg::work_type q_data;

   cdds_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .work_valid  (f_valid),
      .work_stall  (f_stall),
      .work_data   (f_data)
   );

   cdds_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_stall  (f_stall),
      .in_data   (f_data),
      .out_valid (q_valid),
      .out_stall (q_stall),
      .out_data  (q_data)
   );

   cdds_back u_back (
      .clock       (clock),
      .reset       (reset),
      .work_valid  (q_valid),
      .work_stall  (q_stall),
      .work_data   (q_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule
